>>> rtl/core/i2cee_pkg.sv
// Shared types and constants for the I2C EEPROM transfer sequencer.
// Holds the action, status, operation, mode and bus status codes and the beat structs.
// No dependencies.
`timescale 1ns / 1ps

package i2cee_pkg;

  localparam int BufferDepth = 64;
  localparam int MemoryBytes = 32768;
  localparam int BufAddrW    = $clog2(BufferDepth);
  localparam int SumW        = 17;

  localparam logic [7:0] SlaveBase = 8'hA0;
  localparam logic [7:0] ReadBit   = 8'h01;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_START   = 3'd2,
    ACT_STOP    = 3'd3,
    ACT_ACK     = 3'd4,
    ACT_NACK    = 3'd5,
    ACT_RESTART = 3'd6,
    ACT_DISABLE = 3'd7
  } act_e;

  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_BUSY  = 2'd1,
    ST_OK    = 2'd2,
    ST_ERROR = 2'd3
  } st_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_BEGIN  = 2'd1,
    MODE_STATUS = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_e;

  localparam logic [3:0] CodeStart     = 4'd1;
  localparam logic [3:0] CodeRestart   = 4'd2;
  localparam logic [3:0] CodeAddrWAck  = 4'd3;
  localparam logic [3:0] CodeAddrWNack = 4'd4;
  localparam logic [3:0] CodeDataWAck  = 4'd5;
  localparam logic [3:0] CodeDataWNack = 4'd6;
  localparam logic [3:0] CodeArbLost   = 4'd7;
  localparam logic [3:0] CodeAddrRAck  = 4'd8;
  localparam logic [3:0] CodeAddrRNack = 4'd9;
  localparam logic [3:0] CodeDataRAck  = 4'd10;
  localparam logic [3:0] CodeDataRNack = 4'd11;
  localparam logic [3:0] CodeBusError  = 4'd12;

  localparam logic [1:0] RegChipSelect = 2'd0;
  localparam logic [1:0] RegStartAddr  = 2'd1;
  localparam logic [1:0] RegLength     = 2'd2;
  localparam logic [1:0] RegDirection  = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] status_code;
    logic [5:0] load_index;
    logic [7:0] load_byte;
    logic [7:0] received_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  chip_select;
    logic [14:0] start_address;
    logic [6:0]  transfer_length;
    logic        direction;
  } cfg_t;

  typedef struct packed {
    act_e       bus_action;
    logic [7:0] send_byte;
    logic       read_valid;
    logic [5:0] read_index;
    logic [7:0] read_data;
    st_e        transfer_status;
  } res_t;

endpackage

>>> rtl/core/i2cee_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module i2cee_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/i2cee_ctrl.sv
// Transfer state and the decision logic that answers one beat with one result.
// Depends on i2cee_pkg.
`timescale 1ns / 1ps

module i2cee_ctrl import i2cee_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  item_t               item_i,
  input  cfg_t                cfg_i,
  input  logic [7:0]          buf_byte_i,
  output res_t                res_o,
  output logic [BufAddrW-1:0] rd_addr_o
);

  logic [1:0] addr_left_q, addr_left_d;
  logic [6:0] count_q, count_d;
  logic [6:0] eff_len_q, eff_len_d;
  op_e        op_q, op_d;
  st_e        st_q, st_d;

  logic [7:0]      slave_addr;
  logic [6:0]      count_bump;
  logic [7:0]      count_next_plus;
  logic [SumW-1:0] addr_ext;
  logic [SumW-1:0] sum;
  logic [SumW-1:0] len_cut;
  logic            rd;
  logic [3:0]      code;

  always_comb begin
    slave_addr      = SlaveBase | {4'b0, cfg_i.chip_select, 1'b0};
    count_bump      = (count_q < 7'd127) ? count_q + 7'd1 : count_q;
    count_next_plus = {1'b0, count_bump} + 8'd1;
    addr_ext        = {{(SumW-15){1'b0}}, cfg_i.start_address};
    sum             = addr_ext + {{(SumW-7){1'b0}}, cfg_i.transfer_length};
    rd              = (op_q == OP_READ);
    code            = item_i.status_code;

    if (addr_ext >= SumW'(MemoryBytes)) begin
      len_cut = '0;
    end else if (sum > SumW'(MemoryBytes)) begin
      len_cut = SumW'(MemoryBytes) - addr_ext;
    end else begin
      len_cut = {{(SumW-7){1'b0}}, cfg_i.transfer_length};
    end
    if (len_cut > SumW'(BufferDepth)) begin
      len_cut = SumW'(BufferDepth);
    end

    addr_left_d = addr_left_q;
    count_d     = count_q;
    eff_len_d   = eff_len_q;
    op_d        = op_q;
    st_d        = st_q;

    res_o = '{bus_action: ACT_NONE, send_byte: 8'd0, read_valid: 1'b0,
              read_index: 6'd0, read_data: 8'd0, transfer_status: ST_READY};

    case (mode_e'(item_i.mode))
      MODE_BEGIN: begin
        eff_len_d        = len_cut[6:0];
        addr_left_d      = 2'd2;
        count_d          = '0;
        op_d             = cfg_i.direction ? OP_READ : OP_WRITE;
        st_d             = ST_BUSY;
        res_o.bus_action = ACT_START;
      end
      MODE_STATUS: begin
        if (code == CodeArbLost) begin
          addr_left_d      = 2'd2;
          count_d          = '0;
          res_o.bus_action = ACT_RESTART;
        end else if (code == CodeAddrWNack || code == CodeDataWNack ||
                     code == CodeAddrRNack || code == CodeBusError) begin
          st_d             = ST_ERROR;
          op_d             = OP_NONE;
          res_o.bus_action = ACT_DISABLE;
        end else if (op_q == OP_WRITE || op_q == OP_READ) begin
          if (code == CodeStart) begin
            res_o.bus_action = ACT_SEND;
            res_o.send_byte  = slave_addr;
          end else if (code == CodeAddrWAck || code == CodeDataWAck) begin
            if (addr_left_q != 2'd0) begin
              res_o.bus_action = ACT_SEND;
              res_o.send_byte  = (addr_left_q == 2'd2) ?
                                 {1'b0, cfg_i.start_address[14:8]} :
                                 cfg_i.start_address[7:0];
              addr_left_d      = addr_left_q - 2'd1;
            end else if (rd) begin
              res_o.bus_action = ACT_START;
            end else if (count_q < eff_len_q) begin
              res_o.bus_action = ACT_SEND;
              res_o.send_byte  = buf_byte_i;
              count_d          = count_bump;
            end else begin
              res_o.bus_action = ACT_STOP;
              op_d             = OP_NONE;
              st_d             = ST_OK;
            end
          end else if (rd && code == CodeRestart) begin
            res_o.bus_action = ACT_SEND;
            res_o.send_byte  = slave_addr | ReadBit;
          end else if (rd && code == CodeDataRAck) begin
            res_o.read_valid = 1'b1;
            res_o.read_index = count_q[5:0];
            res_o.read_data  = item_i.received_byte;
            count_d          = count_bump;
            res_o.bus_action = (count_next_plus < {1'b0, eff_len_q}) ? ACT_ACK : ACT_NACK;
          end else if (rd && code == CodeAddrRAck) begin
            res_o.bus_action = ({1'b0, count_q} + 8'd1 < {1'b0, eff_len_q}) ?
                               ACT_ACK : ACT_NACK;
          end else if (rd && code == CodeDataRNack) begin
            res_o.read_valid = 1'b1;
            res_o.read_index = count_q[5:0];
            res_o.read_data  = item_i.received_byte;
            res_o.bus_action = ACT_STOP;
            op_d             = OP_NONE;
            st_d             = ST_OK;
          end
        end
      end
      default: ;
    endcase

    res_o.transfer_status = st_d;

    if (!fire_i) begin
      addr_left_d = addr_left_q;
      count_d     = count_q;
      eff_len_d   = eff_len_q;
      op_d        = op_q;
      st_d        = st_q;
    end
    rd_addr_o = count_d[BufAddrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_left_q <= 2'd2;
      count_q     <= '0;
      eff_len_q   <= '0;
      op_q        <= OP_NONE;
      st_q        <= ST_READY;
    end else begin
      addr_left_q <= addr_left_d;
      count_q     <= count_d;
      eff_len_q   <= eff_len_d;
      op_q        <= op_d;
      st_q        <= st_d;
    end
  end

endmodule

>>> rtl/core/i2c_eeprom_transfer_sequencer.sv
// Top level of the I2C EEPROM transfer sequencer: input and result registers,
// configuration registers and the write buffer. Depends on i2cee_pkg, i2cee_ram, i2cee_ctrl.
// An accepted input beat is held in the input register, and its result is registered in the result register.
// Throughput: one beat per cycle; the input register drains whenever the result
// register is empty or its beat is taken in the same cycle.
// Reset clears transfer state to ready and the configuration registers to their
// defaults; write buffer contents are undefined until loaded.
`timescale 1ns / 1ps

module i2c_eeprom_transfer_sequencer import i2cee_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [3:0]  status_code_i,
  input  logic [5:0]  load_index_i,
  input  logic [7:0]  load_byte_i,
  input  logic [7:0]  received_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  bus_action_o,
  output logic [7:0]  send_byte_o,
  output logic        read_valid_o,
  output logic [5:0]  read_index_o,
  output logic [7:0]  read_data_o,
  output logic [1:0]  transfer_status_o
);

  cfg_t  cfg_q;
  item_t item_q;
  logic  in_valid_q;
  logic  out_valid_q;
  res_t  res_q;
  res_t  res;
  logic  fire;

  logic                wr_en;
  logic [BufAddrW-1:0] wr_addr;
  logic [BufAddrW-1:0] rd_addr;
  logic [7:0]          ram_rdata;
  logic                byp_q;
  logic [7:0]          byp_data_q;
  logic [7:0]          buf_byte;

  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  assign wr_en    = fire && (mode_e'(item_q.mode) == MODE_LOAD);
  assign wr_addr  = item_q.load_index[BufAddrW-1:0];
  assign buf_byte = byp_q ? byp_data_q : ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '{chip_select: 3'd0, start_address: 15'd0,
                       transfer_length: 7'd1, direction: 1'b0};
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegChipSelect: cfg_q.chip_select     <= cfg_data_i[2:0];
          RegStartAddr:  cfg_q.start_address   <= cfg_data_i;
          RegLength:     cfg_q.transfer_length <= cfg_data_i[6:0];
          RegDirection:  cfg_q.direction       <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      byp_q <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= '{mode: mode_i, status_code: status_code_i, load_index: load_index_i,
                  load_byte: load_byte_i, received_byte: received_byte_i};
    end
    if (fire) begin
      res_q <= res;
    end
    byp_data_q <= item_q.load_byte;
  end

  i2cee_ram #(
    .Width (8),
    .Depth (BufferDepth)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (item_q.load_byte),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  i2cee_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (item_q),
    .cfg_i      (cfg_q),
    .buf_byte_i (buf_byte),
    .res_o      (res),
    .rd_addr_o  (rd_addr)
  );

  assign out_valid_o       = out_valid_q;
  assign bus_action_o      = res_q.bus_action;
  assign send_byte_o       = res_q.send_byte;
  assign read_valid_o      = res_q.read_valid;
  assign read_index_o      = res_q.read_index;
  assign read_data_o       = res_q.read_data;
  assign transfer_status_o = res_q.transfer_status;

endmodule

>>> bench/testbench.sv
// Self-checking bench for the I2C EEPROM transfer sequencer: directed edge cases, back-pressure
// and random bus transfers, each result beat checked against a cycle-free predictor.
// Depends on i2cee_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module testbench;
  import i2cee_pkg::*;

  localparam int CycleLimit = 200000;
  localparam logic [3:0] CodeNone   = 4'd0;
  localparam logic [3:0] CodeUnused = 4'd13;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [14:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [3:0]  status_code_i;
  logic [5:0]  load_index_i;
  logic [7:0]  load_byte_i;
  logic [7:0]  received_byte_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  bus_action_o;
  logic [7:0]  send_byte_o;
  logic        read_valid_o;
  logic [5:0]  read_index_o;
  logic [7:0]  read_data_o;
  logic [1:0]  transfer_status_o;

  logic [7:0] wbuf [BufferDepth];
  bit         wbuf_loaded [BufferDepth];
  logic [1:0] addr_bytes_left;
  logic [6:0] bytes_done;
  logic [6:0] eff_len;
  op_e        cur_op;
  st_e        xfer_status;
  cfg_t       cfg_shadow;
  res_t       pending_answers [$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off_left = 0;
  int beats_sent = 0;
  int mismatches = 0;
  int cycle_count = 0;

  i2c_eeprom_transfer_sequencer dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: no progress within %0d cycles", $time, CycleLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      out_stall_i <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic res_t answer_beat(input item_t it);
    res_t       a;
    int         len;
    logic [7:0] slave;
    a = '0;
    slave = SlaveBase | {4'd0, cfg_shadow.chip_select, 1'b0};
    case (mode_e'(it.mode))
      MODE_LOAD: begin
        wbuf[it.load_index] = it.load_byte;
        wbuf_loaded[it.load_index] = 1'b1;
      end
      MODE_BEGIN: begin
        len = int'(cfg_shadow.transfer_length);
        if (int'(cfg_shadow.start_address) + len > MemoryBytes) begin
          len = MemoryBytes - int'(cfg_shadow.start_address);
        end
        if (len > BufferDepth) len = BufferDepth;
        eff_len = 7'(len);
        addr_bytes_left = 2'd2;
        bytes_done = 7'd0;
        cur_op = cfg_shadow.direction ? OP_READ : OP_WRITE;
        xfer_status = ST_BUSY;
        a.bus_action = ACT_START;
      end
      MODE_STATUS: begin
        if (it.status_code == CodeArbLost) begin
          addr_bytes_left = 2'd2;
          bytes_done = 7'd0;
          a.bus_action = ACT_RESTART;
        end else if (it.status_code == CodeAddrWNack || it.status_code == CodeDataWNack ||
                     it.status_code == CodeAddrRNack || it.status_code == CodeBusError) begin
          xfer_status = ST_ERROR;
          cur_op = OP_NONE;
          a.bus_action = ACT_DISABLE;
        end else if (cur_op != OP_NONE) begin
          if (it.status_code == CodeStart) begin
            a.bus_action = ACT_SEND;
            a.send_byte = slave;
          end else if (it.status_code == CodeAddrWAck || it.status_code == CodeDataWAck) begin
            if (addr_bytes_left != 2'd0) begin
              a.bus_action = ACT_SEND;
              a.send_byte = (addr_bytes_left == 2'd2) ?
                  {1'b0, cfg_shadow.start_address[14:8]} : cfg_shadow.start_address[7:0];
              addr_bytes_left--;
            end else if (cur_op == OP_READ) begin
              a.bus_action = ACT_START;
            end else if (bytes_done < eff_len) begin
              a.bus_action = ACT_SEND;
              a.send_byte = wbuf[bytes_done[5:0]];
              if (bytes_done != 7'd127) bytes_done++;
            end else begin
              a.bus_action = ACT_STOP;
              cur_op = OP_NONE;
              xfer_status = ST_OK;
            end
          end else if (cur_op == OP_READ) begin
            if (it.status_code == CodeRestart) begin
              a.bus_action = ACT_SEND;
              a.send_byte = slave | ReadBit;
            end else if (it.status_code == CodeDataRAck || it.status_code == CodeAddrRAck) begin
              if (it.status_code == CodeDataRAck) begin
                a.read_valid = 1'b1;
                a.read_index = bytes_done[5:0];
                a.read_data = it.received_byte;
                if (bytes_done != 7'd127) bytes_done++;
              end
              a.bus_action = (int'(bytes_done) + 1 < int'(eff_len)) ? ACT_ACK : ACT_NACK;
            end else if (it.status_code == CodeDataRNack) begin
              a.read_valid = 1'b1;
              a.read_index = bytes_done[5:0];
              a.read_data = it.received_byte;
              a.bus_action = ACT_STOP;
              cur_op = OP_NONE;
              xfer_status = ST_OK;
            end
          end
        end
      end
      default: ;
    endcase
    a.transfer_status = xfer_status;
    return a;
  endfunction

  function automatic item_t load_beat(input logic [5:0] idx, input logic [7:0] value);
    item_t it;
    it = 28'($urandom);
    it.mode = MODE_LOAD;
    it.load_index = idx;
    it.load_byte = value;
    return it;
  endfunction

  function automatic item_t begin_beat();
    item_t it;
    it = 28'($urandom);
    it.mode = MODE_BEGIN;
    return it;
  endfunction

  function automatic item_t status_beat(input logic [3:0] code);
    item_t it;
    it = 28'($urandom);
    it.mode = MODE_STATUS;
    it.status_code = code;
    return it;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result beat expected none, got action %0d status %0d", $time,
                 bus_action_o, transfer_status_o);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        check_field("bus_action", int'(want.bus_action), int'(bus_action_o));
        check_field("send_byte", int'(want.send_byte), int'(send_byte_o));
        check_field("read_valid", int'(want.read_valid), int'(read_valid_o));
        check_field("read_index", int'(want.read_index), int'(read_index_o));
        check_field("read_data", int'(want.read_data), int'(read_data_o));
        check_field("transfer_status", int'(want.transfer_status), int'(transfer_status_o));
      end
    end
  end

  task automatic drive_beat(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= it.mode;
    status_code_i   <= it.status_code;
    load_index_i    <= it.load_index;
    load_byte_i     <= it.load_byte;
    received_byte_i <= it.received_byte;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_answers.push_back(answer_beat(it));
    beats_sent++;
  endtask

  // A write transfer must never send a buffer entry that has not been loaded.
  task automatic send_beat(input item_t it);
    if (it.mode == MODE_STATUS && cur_op == OP_WRITE && addr_bytes_left == 2'd0 &&
        (it.status_code == CodeAddrWAck || it.status_code == CodeDataWAck) &&
        bytes_done < eff_len && !wbuf_loaded[bytes_done[5:0]]) begin
      drive_beat(load_beat(bytes_done[5:0], 8'($urandom)));
    end
    drive_beat(it);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [14:0] value);
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [2:0] cs, input logic [14:0] addr,
                              input logic [6:0] len, input logic rd);
    wait_idle();
    cfg_we_i <= 1'b1;
    put_reg(RegChipSelect, {12'd0, cs});
    put_reg(RegStartAddr, addr);
    put_reg(RegLength, {8'd0, len});
    put_reg(RegDirection, {14'd0, rd});
    cfg_we_i <= 1'b0;
    cfg_shadow.chip_select = cs;
    cfg_shadow.start_address = addr;
    cfg_shadow.transfer_length = len;
    cfg_shadow.direction = rd;
  endtask

  task automatic random_config();
    logic [14:0] addr;
    logic [6:0]  len;
    if ($urandom_range(4) == 0) begin
      addr = 15'(MemoryBytes - 1 - int'($urandom_range(70)));
    end else begin
      addr = 15'($urandom);
    end
    case ($urandom_range(9))
      0: len = 7'($urandom_range(127));
      1, 2: len = 7'($urandom_range(64, 9));
      default: len = 7'($urandom_range(8, 1));
    endcase
    apply_config(3'($urandom_range(7)), addr, len, 1'($urandom_range(1)));
  endtask

  // One well-formed transfer with the odd lost arbitration, fault or stray beat mixed in.
  task automatic random_transfer();
    logic [3:0] codes [$];
    logic [3:0] fault;
    int         i;
    int         k;
    int         r;
    bit         rewound;
    send_beat(begin_beat());
    if (cur_op == OP_WRITE) begin
      for (k = 0; k < int'(eff_len); k++) begin
        if ($urandom_range(1) == 1) send_beat(load_beat(6'(k), 8'($urandom)));
      end
    end
    codes.push_back(CodeStart);
    codes.push_back(CodeAddrWAck);
    codes.push_back(CodeDataWAck);
    codes.push_back(CodeDataWAck);
    if (cur_op == OP_READ) begin
      codes.push_back(CodeRestart);
      codes.push_back(CodeAddrRAck);
      for (k = 1; k < int'(eff_len); k++) codes.push_back(CodeDataRAck);
      codes.push_back(CodeDataRNack);
    end else begin
      for (k = 0; k < int'(eff_len); k++) codes.push_back(CodeDataWAck);
    end
    rewound = 1'b0;
    i = 0;
    while (i < codes.size()) begin
      r = int'($urandom_range(99));
      if (r < 2 && !rewound) begin
        send_beat(status_beat(CodeArbLost));
        rewound = 1'b1;
        i = 0;
      end else if (r < 4) begin
        case ($urandom_range(3))
          0: fault = CodeAddrWNack;
          1: fault = CodeDataWNack;
          2: fault = CodeAddrRNack;
          default: fault = CodeBusError;
        endcase
        send_beat(status_beat(fault));
        i = codes.size();
      end else if (r < 8) begin
        send_beat(28'($urandom));
      end else begin
        send_beat(status_beat(codes[i]));
        i++;
      end
    end
  endtask

  task automatic test_page_write_edges();
    item_t spare;
    apply_config(3'd7, 15'h7FFF, 7'd127, 1'b0);
    send_beat(load_beat(6'd63, 8'hFF));
    send_beat(load_beat(6'd0, 8'h00));
    spare = status_beat(CodeNone);
    spare.mode = MODE_SPARE;
    send_beat(spare);
    send_beat(status_beat(CodeNone));
    send_beat(status_beat(CodeUnused));
    send_beat(status_beat(CodeAddrWAck));
    send_beat(begin_beat());
    send_beat(status_beat(CodeStart));
    send_beat(status_beat(CodeAddrWAck));
    send_beat(status_beat(CodeDataWAck));
    send_beat(status_beat(CodeDataWAck));
    send_beat(status_beat(CodeDataWAck));
  endtask

  task automatic test_zero_length_write();
    apply_config(3'd0, 15'h0000, 7'd0, 1'b0);
    send_beat(begin_beat());
    send_beat(status_beat(CodeStart));
    send_beat(status_beat(CodeAddrWAck));
    send_beat(status_beat(CodeDataWAck));
    send_beat(status_beat(CodeDataWAck));
    send_beat(status_beat(CodeBusError));
  endtask

  task automatic test_read_arbitration();
    apply_config(3'd5, 15'h2A55, 7'd0, 1'b1);
    send_beat(begin_beat());
    send_beat(status_beat(CodeStart));
    send_beat(status_beat(CodeArbLost));
    send_beat(status_beat(CodeStart));
    send_beat(status_beat(CodeAddrWAck));
    send_beat(status_beat(CodeDataWAck));
    send_beat(status_beat(CodeDataWAck));
    send_beat(status_beat(CodeRestart));
    send_beat(status_beat(CodeAddrRAck));
    send_beat(status_beat(CodeAddrWNack));
  endtask

  task automatic test_count_saturation();
    apply_config(3'd2, 15'h0100, 7'd64, 1'b1);
    send_beat(begin_beat());
    send_beat(status_beat(CodeStart));
    send_beat(status_beat(CodeAddrWAck));
    send_beat(status_beat(CodeDataWAck));
    send_beat(status_beat(CodeDataWAck));
    send_beat(status_beat(CodeRestart));
    send_beat(status_beat(CodeAddrRAck));
    repeat (130) send_beat(status_beat(CodeDataRAck));
    send_beat(status_beat(CodeDataRNack));
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    apply_config(3'd3, 15'h0040, 7'd8, 1'b0);
    hold_off_left = 60;
    random_transfer();
    wait_idle();
    random_transfer();
  endtask

  task automatic test_random_traffic(input int in_idle, input int out_idle, input int beats);
    int goal;
    send_idle_pct = in_idle;
    stall_pct = out_idle;
    goal = beats_sent + beats;
    while (beats_sent < goal) begin
      random_config();
      repeat ($urandom_range(3, 1)) begin
        random_transfer();
        if ($urandom_range(5) == 0) wait_idle();
      end
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= RegChipSelect;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    mode_i          <= MODE_LOAD;
    status_code_i   <= CodeNone;
    load_index_i    <= '0;
    load_byte_i     <= '0;
    received_byte_i <= '0;
    addr_bytes_left = 2'd2;
    bytes_done = 7'd0;
    eff_len = 7'd0;
    cur_op = OP_NONE;
    xfer_status = ST_READY;
    cfg_shadow = '0;
    cfg_shadow.transfer_length = 7'd1;
    foreach (wbuf_loaded[k]) wbuf_loaded[k] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_page_write_edges();
    test_zero_length_write();
    test_read_arbitration();
    test_count_saturation();
    test_backpressure();
    test_random_traffic(0, 0, 420);
    test_random_traffic(77, 0, 420);
    test_random_traffic(0, 77, 420);
    test_random_traffic(35, 35, 420);

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
